@@ design/otms_pkg.sv @@
// Shared types and constants for the obstacle-triggered motion sequencer.
package otms_pkg;

  typedef enum logic [2:0] {
    PH_FORWARD = 3'd0,
    PH_STOP    = 3'd1,
    PH_LEFT    = 3'd2,
    PH_AGAIN   = 3'd3,
    PH_RIGHT   = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_CONFIRM   = 3'd1,
    REG_STOP_WAIT = 3'd2,
    REG_LEFT      = 3'd3,
    REG_AGAIN     = 3'd4,
    REG_RIGHT     = 3'd5,
    REG_LIMIT     = 3'd6
  } cfg_reg_e;

  localparam int unsigned NumMotors = 3;

  localparam logic [15:0] DistMinTenth = 16'd20;
  localparam logic [15:0] DistMaxTenth = 16'd4000;
  localparam logic [6:0]  LimitMax     = 7'd100;

  // 1023 * 5243, paired with a shift of 19: exact floor(1023 * m / 100) for m <= 100
  localparam logic [22:0] DutyMul   = 23'd5363589;
  localparam int unsigned DutyShift = 19;

  localparam logic signed [7:0] RawFwd   [NumMotors] = '{-8'sd20, 8'sd0, 8'sd25};
  localparam logic signed [7:0] RawLeft  [NumMotors] = '{-8'sd24, -8'sd30, -8'sd18};
  localparam logic signed [7:0] RawRight [NumMotors] = '{8'sd18, 8'sd30, 8'sd24};
  localparam logic [NumMotors-1:0] MotorNeg = 3'b100;

  typedef struct packed {
    logic [9:0]  tick_ms;
    logic        sample_new;
    logic [15:0] distance_tenth_cm;
  } in_req_t;

  typedef struct packed {
    logic [2:0]        motion_phase;
    logic signed [7:0] drive_a;
    logic signed [7:0] drive_b;
    logic signed [7:0] drive_d;
    logic [9:0]        duty_a;
    logic [9:0]        duty_b;
    logic [9:0]        duty_d;
    logic              standby_on;
    logic [7:0]        close_count;
    logic [2:0]        direction_changed;
  } out_res_t;

  typedef struct packed {
    logic signed [7:0] raw;
    logic              negate;
    logic              zero_after;
  } motor_cmd_t;

  typedef struct packed {
    dir_e dir;
    logic changed;
  } motor_stat_t;

endpackage

@@ design/obstacle_triggered_motion_sequencer_core.sv @@
// Top level of the obstacle-triggered motion sequencer.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i) takes one control tick per
//   request: elapsed milliseconds and an optional distance sample in 0.1 cm.
//   Output channel (out_valid_o / out_stall_i / out_res_o) returns one result per
//   tick: phase, three motor commands, PWM duties, standby, close count and the
//   direction-change mask.
//   The result is registered: a tick accepted in one cycle is shown in the next.
//   Throughput is one tick per cycle unless the output stalls; the phase, timer,
//   counter and direction registers update at the accepting edge, and the result
//   sits in the output register, so the next tick is taken in the same cycle the
//   result is taken. While the receiver stalls with a result pending, in_stall_o
//   is high and the result holds.
//   Reset puts the block in the forward phase with timer and close count at zero,
//   all motors stopped and the registers at their default values.
//   The APB port writes and reads the seven registers at byte address 4*i; write
//   them only while no tick is in flight.
module obstacle_triggered_motion_sequencer_core #(
  parameter int unsigned TIMER_BITS = 16,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  otms_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output otms_pkg::out_res_t  out_res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import otms_pkg::*;

  localparam int unsigned SumW = (TIMER_BITS > 10 ? TIMER_BITS : 10) + 1;
  localparam int unsigned CmpW = TIMER_BITS > 16 ? TIMER_BITS : 16;
  localparam int unsigned CcW  = COUNT_BITS > 8 ? COUNT_BITS : 8;

  logic [11:0] thresh_q;
  logic [7:0]  confirm_q;
  logic [15:0] stop_ms_q;
  logic [15:0] left_ms_q;
  logic [15:0] again_ms_q;
  logic [15:0] right_ms_q;
  logic [6:0]  limit_q;

  phase_e                phase_q, phase_d, phase_mid;
  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_sat, timer_mid;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_upd;
  dir_e                  last_dir_q [NumMotors];

  logic                  out_valid_q;
  out_res_t              out_q, out_d;

  logic [SumW-1:0]       sum;
  logic [CmpW-1:0]       timer_ext;
  logic [CcW-1:0]        cnt_ext;
  logic                  close_hit;
  logic                  confirm;
  logic                  right_done;
  logic                  in_fire;
  logic                  cfg_wr;
  cfg_reg_e              cfg_sel;
  logic [6:0]            lim;

  motor_cmd_t            mcmd  [NumMotors];
  motor_stat_t           mstat [NumMotors];
  logic signed [7:0]     eff   [NumMotors];
  logic [9:0]            duty  [NumMotors];

  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= 12'd100;
      confirm_q  <= 8'd2;
      stop_ms_q  <= 16'd500;
      left_ms_q  <= 16'd1500;
      again_ms_q <= 16'd1000;
      right_ms_q <= 16'd1500;
      limit_q    <= 7'd40;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_THRESHOLD: thresh_q   <= pwdata[11:0];
        REG_CONFIRM:   confirm_q  <= pwdata[7:0];
        REG_STOP_WAIT: stop_ms_q  <= pwdata[15:0];
        REG_LEFT:      left_ms_q  <= pwdata[15:0];
        REG_AGAIN:     again_ms_q <= pwdata[15:0];
        REG_RIGHT:     right_ms_q <= pwdata[15:0];
        REG_LIMIT:     limit_q    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_THRESHOLD: prdata = 32'(thresh_q);
      REG_CONFIRM:   prdata = 32'(confirm_q);
      REG_STOP_WAIT: prdata = 32'(stop_ms_q);
      REG_LEFT:      prdata = 32'(left_ms_q);
      REG_AGAIN:     prdata = 32'(again_ms_q);
      REG_RIGHT:     prdata = 32'(right_ms_q);
      REG_LIMIT:     prdata = 32'(limit_q);
      default:       prdata = 32'd0;
    endcase
  end

  // Next state
  always_comb begin
    sum = SumW'(timer_q) + SumW'(in_req_i.tick_ms);
    if (sum > SumW'({TIMER_BITS{1'b1}})) begin
      timer_sat = {TIMER_BITS{1'b1}};
    end else begin
      timer_sat = sum[TIMER_BITS-1:0];
    end

    close_hit = (in_req_i.distance_tenth_cm >= DistMinTenth) &&
                (in_req_i.distance_tenth_cm <= DistMaxTenth) &&
                (in_req_i.distance_tenth_cm <= 16'(thresh_q));
    cnt_upd = cnt_q;
    if (in_req_i.sample_new) begin
      if (!close_hit) begin
        cnt_upd = '0;
      end else if (cnt_q != {COUNT_BITS{1'b1}}) begin
        cnt_upd = cnt_q + COUNT_BITS'(1);
      end
    end

    confirm   = (phase_q == PH_FORWARD) && (CcW'(cnt_upd) >= CcW'(confirm_q));
    phase_mid = confirm ? PH_STOP : phase_q;
    timer_mid = confirm ? '0 : timer_sat;
    cnt_d     = confirm ? '0 : cnt_upd;
    timer_ext = CmpW'(timer_mid);

    phase_d    = phase_mid;
    timer_d    = timer_mid;
    right_done = 1'b0;
    case (phase_mid)
      PH_FORWARD: ;
      PH_STOP: begin
        if (timer_ext >= CmpW'(stop_ms_q)) begin
          phase_d = PH_LEFT;
          timer_d = '0;
        end
      end
      PH_LEFT: begin
        if (timer_ext >= CmpW'(left_ms_q)) begin
          phase_d = PH_AGAIN;
          timer_d = '0;
        end
      end
      PH_AGAIN: begin
        if (timer_ext >= CmpW'(again_ms_q)) begin
          phase_d = PH_RIGHT;
          timer_d = '0;
        end
      end
      PH_RIGHT: begin
        if (timer_ext >= CmpW'(right_ms_q)) begin
          phase_d    = PH_DONE;
          timer_d    = '0;
          right_done = 1'b1;
        end
      end
      default: phase_d = PH_DONE;
    endcase
  end

  // Motor commands
  assign lim = (limit_q > LimitMax) ? LimitMax : limit_q;

  for (genvar m = 0; m < NumMotors; m++) begin : g_motor
    always_comb begin
      mcmd[m].negate     = MotorNeg[m];
      mcmd[m].zero_after = right_done;
      case (phase_mid)
        PH_FORWARD: mcmd[m].raw = RawFwd[m];
        PH_AGAIN:   mcmd[m].raw = RawFwd[m];
        PH_LEFT:    mcmd[m].raw = RawLeft[m];
        PH_RIGHT:   mcmd[m].raw = RawRight[m];
        default:    mcmd[m].raw = 8'sd0;
      endcase
    end

    otms_motor u_motor (
      .lim_i      (lim),
      .cmd_i      (mcmd[m]),
      .last_dir_i (last_dir_q[m]),
      .eff_o      (eff[m]),
      .duty_o     (duty[m]),
      .stat_o     (mstat[m])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        last_dir_q[m] <= DIR_STOP;
      end else if (in_fire) begin
        last_dir_q[m] <= mstat[m].dir;
      end
    end
  end

  // Result
  always_comb begin
    cnt_ext                 = CcW'(cnt_d);
    out_d.motion_phase      = phase_d;
    out_d.drive_a           = eff[0];
    out_d.drive_b           = eff[1];
    out_d.drive_d           = eff[2];
    out_d.duty_a            = duty[0];
    out_d.duty_b            = duty[1];
    out_d.duty_d            = duty[2];
    out_d.standby_on        = (phase_d != PH_DONE);
    out_d.close_count       = (cnt_ext > CcW'(8'hFF)) ? 8'hFF : cnt_ext[7:0];
    out_d.direction_changed = {mstat[2].changed, mstat[1].changed, mstat[0].changed};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FORWARD;
      timer_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        timer_q <= timer_d;
        cnt_q   <= cnt_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("done phase left");

  a_standby_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.standby_on == (out_q.motion_phase != PH_DONE)))
    else $error("standby does not follow phase");

  a_confirm_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_FORWARD && phase_d != PH_FORWARD |=> cnt_q == '0)
    else $error("close count kept after confirm");

  a_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.drive_a == 8'sd0) == (out_q.duty_a == 10'd0)))
    else $error("duty and command disagree");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.motion_phase == PH_STOP |->
      out_q.drive_a == 8'sd0 && out_q.drive_b == 8'sd0 && out_q.drive_d == 8'sd0)
    else $error("motors driven in stop wait");

endmodule

@@ design/otms_motor.sv @@
// One motor channel: clamp, sign, PWM duty and direction tracking.
module otms_motor (
  input  logic [6:0]          lim_i,
  input  otms_pkg::motor_cmd_t cmd_i,
  input  otms_pkg::dir_e      last_dir_i,
  output logic signed [7:0]   eff_o,
  output logic [9:0]          duty_o,
  output otms_pkg::motor_stat_t stat_o
);
  import otms_pkg::*;

  logic signed [7:0] lim_s;
  logic signed [7:0] clamped;
  logic signed [7:0] signed_cmd;
  dir_e              first_dir;
  logic [6:0]        mag;
  logic [29:0]       prod;

  assign lim_s = signed'({1'b0, lim_i});

  always_comb begin
    if (cmd_i.raw > lim_s) begin
      clamped = lim_s;
    end else if (cmd_i.raw < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = cmd_i.raw;
    end
    signed_cmd = cmd_i.negate ? -clamped : clamped;
    if (signed_cmd > 8'sd0) begin
      first_dir = DIR_POS;
    end else if (signed_cmd < 8'sd0) begin
      first_dir = DIR_NEG;
    end else begin
      first_dir = DIR_STOP;
    end
  end

  assign eff_o = cmd_i.zero_after ? 8'sd0 : signed_cmd;
  assign mag   = eff_o[7] ? 7'(-eff_o) : eff_o[6:0];
  assign prod  = 30'(mag) * 30'(DutyMul);
  assign duty_o = prod[DutyShift+9:DutyShift];

  assign stat_o.dir     = cmd_i.zero_after ? DIR_STOP : first_dir;
  assign stat_o.changed = (first_dir != last_dir_i) ||
                          (cmd_i.zero_after && first_dir != DIR_STOP);

endmodule

@@ test/tb_obstacle_triggered_motion_sequencer_core.sv @@
// Testbench for the obstacle-triggered motion sequencer core: directed and random ticks against a predictor.
module tb_obstacle_triggered_motion_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import otms_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int NearLimit = 20;
  localparam int FarLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_req_t     in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_res_t    out_res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  obstacle_triggered_motion_sequencer_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register shadow
  logic [11:0] thr_cfg = 12'd100;
  logic [7:0]  confirm_cfg = 8'd2;
  logic [15:0] stop_cfg = 16'd500;
  logic [15:0] left_cfg = 16'd1500;
  logic [15:0] again_cfg = 16'd1000;
  logic [15:0] right_cfg = 16'd1500;
  logic [6:0]  limit_cfg = 7'd40;

  // sequencer state
  phase_e      ph_q = PH_FORWARD;
  logic [15:0] timer_q = '0;
  logic [7:0]  close_q = '0;
  dir_e        dir_q [3] = '{DIR_STOP, DIR_STOP, DIR_STOP};
  int          eff_q [3] = '{0, 0, 0};
  logic [2:0]  flip_q = '0;

  out_res_t    expected_results [$];
  int          errors = 0;
  int          checked = 0;
  bit          idle_on = 1'b1;

  function automatic logic [31:0] cfg_value(logic [2:0] idx);
    case (idx)
      REG_THRESHOLD: return {20'd0, thr_cfg};
      REG_CONFIRM:   return {24'd0, confirm_cfg};
      REG_STOP_WAIT: return {16'd0, stop_cfg};
      REG_LEFT:      return {16'd0, left_cfg};
      REG_AGAIN:     return {16'd0, again_cfg};
      REG_RIGHT:     return {16'd0, right_cfg};
      REG_LIMIT:     return {25'd0, limit_cfg};
      default:       return '0;
    endcase
  endfunction

  function automatic bit is_close(logic [15:0] d);
    return int'(d) >= NearLimit && int'(d) <= FarLimit && d <= {4'd0, thr_cfg};
  endfunction

  function automatic int clamp_drive(int v);
    int lim;
    lim = (limit_cfg > 7'd100) ? 100 : int'(limit_cfg);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void drive_motors(phase_e p);
    int raw;
    int e;
    dir_e d;
    for (int m = 0; m < 3; m++) begin
      case (p)
        PH_FORWARD, PH_AGAIN: raw = (m == 0) ? -20 : (m == 1) ? 0 : 25;
        PH_LEFT:              raw = (m == 0) ? -24 : (m == 1) ? -30 : -18;
        PH_RIGHT:             raw = (m == 0) ? 18 : (m == 1) ? 30 : 24;
        default:              raw = 0;
      endcase
      e = clamp_drive(clamp_drive(raw) * ((m == 2) ? -1 : 1));
      d = (e > 0) ? DIR_POS : (e < 0) ? DIR_NEG : DIR_STOP;
      if (d != dir_q[m]) begin
        flip_q[m] = 1'b1;
        dir_q[m] = d;
      end
      eff_q[m] = e;
    end
  endfunction

  function automatic void enter_phase(phase_e p);
    ph_q = p;
    timer_q = '0;
    if (p == PH_STOP || p == PH_DONE) drive_motors(p);
  endfunction

  function automatic logic [9:0] duty_of(int e);
    int mag;
    mag = (e < 0) ? -e : e;
    return 10'((1023 * mag) / 100);
  endfunction

  function automatic out_res_t predict_tick(in_req_t r);
    logic [16:0] sum;
    out_res_t o;
    flip_q = '0;
    sum = {1'b0, timer_q} + {7'd0, r.tick_ms};
    timer_q = sum[16] ? 16'hFFFF : sum[15:0];
    if (r.sample_new) begin
      if (is_close(r.distance_tenth_cm)) begin
        if (close_q != 8'hFF) close_q = close_q + 8'd1;
      end else begin
        close_q = '0;
      end
    end
    if (ph_q == PH_FORWARD && close_q >= confirm_cfg) begin
      close_q = '0;
      enter_phase(PH_STOP);
    end
    case (ph_q)
      PH_FORWARD: drive_motors(PH_FORWARD);
      PH_STOP: begin
        drive_motors(PH_STOP);
        if (timer_q >= stop_cfg) enter_phase(PH_LEFT);
      end
      PH_LEFT: begin
        drive_motors(PH_LEFT);
        if (timer_q >= left_cfg) enter_phase(PH_AGAIN);
      end
      PH_AGAIN: begin
        drive_motors(PH_AGAIN);
        if (timer_q >= again_cfg) enter_phase(PH_RIGHT);
      end
      PH_RIGHT: begin
        drive_motors(PH_RIGHT);
        if (timer_q >= right_cfg) enter_phase(PH_DONE);
      end
      default: begin
        ph_q = PH_DONE;
        drive_motors(PH_DONE);
      end
    endcase
    o.motion_phase = ph_q;
    o.drive_a = 8'(eff_q[0]);
    o.drive_b = 8'(eff_q[1]);
    o.drive_d = 8'(eff_q[2]);
    o.duty_a = duty_of(eff_q[0]);
    o.duty_b = duty_of(eff_q[1]);
    o.duty_d = duty_of(eff_q[2]);
    o.standby_on = (ph_q != PH_DONE);
    o.close_count = close_q;
    o.direction_changed = flip_q;
    return o;
  endfunction

  function automatic string show_res(out_res_t r);
    return $sformatf("ph=%0d drv=%0d/%0d/%0d duty=%0d/%0d/%0d stby=%0b cnt=%0d chg=%b",
                     r.motion_phase, r.drive_a, r.drive_b, r.drive_d, r.duty_a, r.duty_b,
                     r.duty_d, r.standby_on, r.close_count, r.direction_changed);
  endfunction

  function automatic in_req_t make_req(int unsigned t, bit n, logic [15:0] d);
    in_req_t r;
    r.tick_ms = 10'(t);
    r.sample_new = n;
    r.distance_tenth_cm = d;
    return r;
  endfunction

  function automatic logic [15:0] pick_distance(bit want_close);
    int thr;
    logic [15:0] d;
    thr = int'(thr_cfg);
    if (want_close && thr >= NearLimit)
      return 16'($urandom_range((thr > FarLimit) ? FarLimit : thr, NearLimit));
    case ($urandom_range(3))
      0: d = 16'($urandom_range(NearLimit - 1));
      1: d = 16'($urandom_range(65535, FarLimit + 1));
      2: d = (thr < FarLimit) ?
             16'($urandom_range(FarLimit, (thr < NearLimit) ? NearLimit : thr + 1)) :
             16'(FarLimit + 1);
      default: d = 16'($urandom);
    endcase
    if (is_close(d)) d[15] = 1'b1;
    return d;
  endfunction

  function automatic in_req_t random_tick(int close_pct, int tick_max, bit guard);
    bit want_close;
    bit fresh;
    want_close = ($urandom_range(99) < close_pct);
    fresh = ($urandom_range(99) < 80);
    // keep the count below the confirm level while still moving forward
    if (guard && ph_q == PH_FORWARD && int'(close_q) + 1 >= int'(confirm_cfg)) begin
      want_close = 1'b0;
      if (int'(close_q) >= int'(confirm_cfg)) fresh = 1'b1;
      else if ($urandom_range(1) == 0) fresh = 1'b0;
    end
    return make_req($urandom_range(tick_max), fresh, pick_distance(want_close));
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic send_tick(in_req_t r);
    if (idle_on) begin
      while ($urandom_range(99) < 29) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    // hold the request until taken
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_tick(r));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_THRESHOLD: thr_cfg = val[11:0];
      REG_CONFIRM:   confirm_cfg = val[7:0];
      REG_STOP_WAIT: stop_cfg = val[15:0];
      REG_LEFT:      left_cfg = val[15:0];
      REG_AGAIN:     again_cfg = val[15:0];
      REG_RIGHT:     right_cfg = val[15:0];
      REG_LIMIT:     limit_cfg = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apb_check(logic [2:0] idx);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== cfg_value(idx))
      note_failure($sformatf("register %0d read: expected %0d got %0d",
                             idx, cfg_value(idx), got));
  endtask

  task automatic check_all_regs();
    for (int i = REG_THRESHOLD; i <= REG_LIMIT; i++) apb_check(3'(i));
  endtask

  task automatic test_reset_values();
    check_all_regs();
  endtask

  task automatic test_register_access();
    apb_write(REG_THRESHOLD, 32'd4095);
    apb_write(REG_CONFIRM, 32'd0);
    apb_write(REG_STOP_WAIT, 32'd65535);
    apb_write(REG_LEFT, 32'd0);
    apb_write(REG_AGAIN, 32'd65535);
    apb_write(REG_RIGHT, 32'd0);
    apb_write(REG_LIMIT, 32'd127);
    check_all_regs();
    apb_write(RegUnused, 32'hFFFF_FFFF);
    check_all_regs();
  endtask

  task automatic test_sample_edges();
    apb_write(REG_THRESHOLD, 32'd4000);
    apb_write(REG_CONFIRM, 32'd255);
    apb_write(REG_LIMIT, 32'd40);
    send_tick(make_req(0, 1'b1, 16'd19));
    send_tick(make_req(1023, 1'b1, 16'd20));
    send_tick(make_req(5, 1'b1, 16'd4000));
    send_tick(make_req(5, 1'b0, 16'd20));
    send_tick(make_req(5, 1'b1, 16'd4001));
    send_tick(make_req(5, 1'b1, 16'd20));
    send_tick(make_req(5, 1'b1, 16'd0));
    send_tick(make_req(5, 1'b1, 16'd20));
    send_tick(make_req(5, 1'b1, 16'd65535));
    settle();
    apb_write(REG_THRESHOLD, 32'd100);
    send_tick(make_req(5, 1'b1, 16'd100));
    send_tick(make_req(5, 1'b1, 16'd101));
    settle();
    apb_write(REG_THRESHOLD, 32'd0);
    send_tick(make_req(5, 1'b1, 16'd20));
    settle();
    apb_write(REG_THRESHOLD, 32'd4095);
    send_tick(make_req(5, 1'b1, 16'd4000));
    send_tick(make_req(5, 1'b1, 16'd4001));
  endtask

  task automatic test_drive_limits();
    int limits [6] = '{0, 127, 100, 10, 25, 40};
    foreach (limits[i]) begin
      settle();
      apb_write(REG_LIMIT, limits[i]);
      send_tick(make_req($urandom_range(1023), 1'b0, 16'($urandom)));
    end
  endtask

  task automatic test_forward_random();
    int close_pct;
    for (int s = 0; s < 5; s++) begin
      settle();
      case (s)
        0: begin
          apb_write(REG_THRESHOLD, 32'd4000);
          apb_write(REG_CONFIRM, 32'd255);
          apb_write(REG_LIMIT, 32'd0);
        end
        1: begin
          apb_write(REG_THRESHOLD, $urandom_range(4095));
          apb_write(REG_CONFIRM, 32'd1);
          apb_write(REG_LIMIT, 32'd127);
        end
        2: begin
          apb_write(REG_THRESHOLD, 32'd0);
          apb_write(REG_CONFIRM, $urandom_range(8, 2));
          apb_write(REG_LIMIT, 32'd100);
        end
        3: begin
          apb_write(REG_THRESHOLD, 32'd4095);
          apb_write(REG_CONFIRM, $urandom_range(20, 2));
          apb_write(REG_LIMIT, $urandom_range(99, 1));
        end
        default: begin
          apb_write(REG_THRESHOLD, $urandom_range(1500, 200));
          apb_write(REG_CONFIRM, $urandom_range(254, 9));
          apb_write(REG_LIMIT, 32'd40);
        end
      endcase
      idle_on = (s != 2);
      close_pct = $urandom_range(90, 30);
      for (int i = 0; i < 160; i++) begin
        if (i == 80) settle();
        send_tick(random_tick(close_pct, 1023, 1'b1));
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic test_obstacle_maneuver();
    settle();
    apb_write(REG_THRESHOLD, 32'd600);
    apb_write(REG_CONFIRM, 32'd4);
    apb_write(REG_STOP_WAIT, 32'd900);
    apb_write(REG_LEFT, 32'd65535);
    apb_write(REG_AGAIN, 32'd0);
    apb_write(REG_RIGHT, $urandom_range(3000, 500));
    apb_write(REG_LIMIT, 32'd30);
    // clear, approach, drop out, then approach until confirmed
    send_tick(make_req($urandom_range(1023), 1'b1, pick_distance(1'b0)));
    repeat (3) send_tick(make_req($urandom_range(1023), 1'b1, pick_distance(1'b1)));
    send_tick(make_req($urandom_range(1023), 1'b1, pick_distance(1'b0)));
    while (ph_q == PH_FORWARD)
      send_tick(make_req($urandom_range(1023), $urandom_range(99) < 75, pick_distance(1'b1)));
    while (ph_q == PH_STOP) send_tick(random_tick(50, 400, 1'b0));
    repeat (20) begin
      if (ph_q == PH_LEFT) send_tick(random_tick(50, 1023, 1'b0));
    end
    settle();
    apb_write(REG_LIMIT, 32'd127);
    while (ph_q == PH_LEFT) send_tick(random_tick(50, 1023, 1'b0));
    settle();
    apb_write(REG_LIMIT, 32'd15);
    while (ph_q != PH_DONE) send_tick(random_tick(50, 1023, 1'b0));
  endtask

  task automatic test_done_random();
    settle();
    apb_write(REG_THRESHOLD, 32'd4095);
    apb_write(REG_CONFIRM, 32'd0);
    apb_write(REG_STOP_WAIT, 32'd0);
    apb_write(REG_RIGHT, 32'd65535);
    idle_on = 1'b0;
    // drive the close count into saturation
    repeat (400)
      send_tick(make_req($urandom_range(1023), $urandom_range(19) != 0, pick_distance(1'b1)));
    idle_on = 1'b1;
    for (int s = 0; s < 3; s++) begin
      settle();
      apb_write(REG_THRESHOLD, $urandom_range(4095));
      apb_write(REG_LIMIT, $urandom_range(127));
      repeat (130) send_tick(random_tick(70, 1023, 1'b0));
    end
  endtask

  always @(posedge clk_i) out_stall_i <= idle_on && ($urandom_range(99) < 29);

  always @(posedge clk_i) begin : check_results
    out_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result with none pending: got %s", show_res(out_res_o)));
      end else begin
        want = expected_results.pop_front();
        if (want !== out_res_o)
          note_failure($sformatf("result %0d: expected %s got %s",
                                 checked, show_res(want), show_res(out_res_o)));
        checked++;
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_obstacle_triggered_motion_sequencer_core: done, errors");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_register_access();
    test_sample_edges();
    test_drive_limits();
    test_forward_random();
    test_obstacle_maneuver();
    test_done_random();
    settle();
    if (errors == 0) begin
      $display("tb_obstacle_triggered_motion_sequencer_core: done, clean");
    end else begin
      $display("tb_obstacle_triggered_motion_sequencer_core: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/otms_pkg.sv
design/otms_motor.sv
design/obstacle_triggered_motion_sequencer_core.sv
test/tb_obstacle_triggered_motion_sequencer_core.sv
